// File: hdl/rtsd_pkg.sv
// Radio telegram sensor decoder: shared types and constants.
// No dependencies; compiled first.
package rtsd_pkg;

    // Frame layout
    localparam int unsigned FRAME_CHARS = 28;
    localparam logic [4:0]  LAST_POS    = 5'(FRAME_CHARS - 1);

    // Configuration port
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SENSOR_COUNT = 3'd0;

    // Frame queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Notification kinds
    localparam logic [2:0] KIND_BTN1  = 3'd0;
    localparam logic [2:0] KIND_BTN2  = 3'd1;
    localparam logic [2:0] KIND_TEMP  = 3'd2;
    localparam logic [2:0] KIND_LIGHT = 3'd3;
    localparam logic [2:0] KIND_VOLT  = 3'd4;

    typedef enum logic [1:0] {
        CLS_ROCKER  = 2'd0,
        CLS_CONTACT = 2'd1,
        CLS_4BS     = 2'd2
    } frame_cls_t;

    // One accepted frame waiting to be turned into notifications.
    // b1/b2 are two-bit two's complement button or contact states.
    typedef struct packed {
        logic [31:0] sender;
        frame_cls_t  cls;
        logic [31:0] data;
        logic [1:0]  b1;
        logic [1:0]  b2;
    } desc_t;

    typedef struct packed {
        logic at_last;
        logic push;
    } front_stat_t;

endpackage

// File: hdl/rtsd_char_if.sv
// Character channel: one ASCII hex character per beat.
// Stand-alone interface, no dependencies.
interface rtsd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] hex_char;

    modport source (output valid, output hex_char, input ready);
    modport sink   (input valid, input hex_char, output ready);
endinterface

// File: hdl/rtsd_note_if.sv
// Notification channel: one sensor result per beat.
// Stand-alone interface, no dependencies.
interface rtsd_note_if;
    logic              valid;
    logic              ready;
    logic [31:0]       sensor_id;
    logic [2:0]        field_kind;
    logic signed [9:0] reading;
    logic              last;

    modport source (output valid, output sensor_id, output field_kind, output reading,
                    output last, input ready);
    modport sink   (input valid, input sensor_id, input field_kind, input reading,
                    input last, output ready);
endinterface

// File: hdl/rtsd_regs.sv
// APB register bank: sensor count and sensor ID table.
// Depends on rtsd_pkg.
module rtsd_regs
    import rtsd_pkg::*;
#(
    parameter int unsigned MAX_SENSORS = 6
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [2:0]                  sensor_count,
    output logic [MAX_SENSORS-1:0][31:0] sensor_ids
);

    logic [REG_IDX_W-1:0]          reg_idx;
    logic                          wr_en;
    logic [2:0]                    count_reg;
    logic [MAX_SENSORS-1:0][31:0]  ids_reg;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ids_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_SENSOR_COUNT)
            begin
                count_reg <= pwdata[2:0];
            end
            for (int i = 0; i < MAX_SENSORS; i++)
            begin
                if (reg_idx == REG_IDX_W'(i + 1))
                begin
                    ids_reg[i] <= pwdata;
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_SENSOR_COUNT)
        begin
            prdata = {29'd0, count_reg};
        end
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            if (reg_idx == REG_IDX_W'(i + 1))
            begin
                prdata = ids_reg[i];
            end
        end
    end

    assign sensor_count = count_reg;
    assign sensor_ids   = ids_reg;

endmodule

// File: hdl/rtsd_front.sv
// Front end: hex character assembly, sender filter and frame classification.
// Depends on rtsd_pkg and rtsd_char_if.
module rtsd_front
    import rtsd_pkg::*;
#(
    parameter int unsigned MAX_SENSORS = 6
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    rtsd_char_if.sink                    char_in,
    input  logic [2:0]                   sensor_count,
    input  logic [MAX_SENSORS-1:0][31:0] sensor_ids,
    input  logic                         q_full,
    output desc_t                        push_desc,
    output front_stat_t                  stat
);

    localparam logic [2:0] MAX_CNT = 3'(MAX_SENSORS);

    localparam logic [7:0] TYPE_ROCKER  = 8'h05;
    localparam logic [7:0] TYPE_CONTACT = 8'h06;
    localparam logic [7:0] TYPE_4BS     = 8'h07;
    localparam logic [7:0] CONTACT_OPEN = 8'h08;
    localparam logic [7:0] CONTACT_SHUT = 8'h09;

    localparam logic [7:0] RK_B1_DOWN  = 8'h10;
    localparam logic [7:0] RK_B1_UP    = 8'h30;
    localparam logic [7:0] RK_B2_DOWN  = 8'h50;
    localparam logic [7:0] RK_B2_UP    = 8'h70;
    localparam logic [7:0] RK_UP_UP    = 8'h37;
    localparam logic [7:0] RK_DN_DN    = 8'h15;
    localparam logic [7:0] RK_DN_UP    = 8'h17;
    localparam logic [7:0] RK_UP_DN    = 8'h35;
    localparam logic [7:0] RK_RELEASED = 8'h00;

    localparam logic [1:0] ST_DOWN = 2'b11;
    localparam logic [1:0] ST_ZERO = 2'b00;
    localparam logic [1:0] ST_UP   = 2'b01;

    logic [4:0]  pos_reg,    pos_next;
    logic [3:0]  hi_reg,     hi_next;
    logic [7:0]  type_reg,   type_next;
    logic [31:0] data_reg,   data_next;
    logic [31:0] sender_reg, sender_next;
    logic        bad_reg,    bad_next;
    logic        match_reg,  match_next;

    logic        accept;
    logic        at_last;
    logic [3:0]  nib;
    logic        hex_ok;
    logic [7:0]  byte_val;
    logic [3:0]  byte_idx;
    logic [2:0]  n_eff;
    logic        cls_ok;
    frame_cls_t  cls;
    logic [1:0]  b1, b2;

    assign at_last       = (pos_reg == LAST_POS);
    assign char_in.ready = !(at_last && q_full);
    assign accept        = char_in.valid && char_in.ready;

    // ASCII hex decode; anything else reads as zero and flags the frame
    always_comb
    begin
        nib    = 4'd0;
        hex_ok = 1'b1;
        priority if (char_in.hex_char >= 8'h30 && char_in.hex_char <= 8'h39)
        begin
            nib = char_in.hex_char[3:0];
        end
        else if ((char_in.hex_char >= 8'h41 && char_in.hex_char <= 8'h46) ||
                 (char_in.hex_char >= 8'h61 && char_in.hex_char <= 8'h66))
        begin
            nib = char_in.hex_char[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign byte_val = {hi_reg, nib};
    assign byte_idx = pos_reg[4:1];

    always_comb
    begin
        pos_next    = pos_reg;
        hi_next     = hi_reg;
        type_next   = type_reg;
        data_next   = data_reg;
        sender_next = sender_reg;
        bad_next    = bad_reg;
        if (accept)
        begin
            if (!pos_reg[0])
            begin
                hi_next = nib;
            end
            else if (byte_idx == 4'd3)
            begin
                type_next = byte_val;
            end
            else if (byte_idx >= 4'd4 && byte_idx <= 4'd7)
            begin
                data_next = {data_reg[23:0], byte_val};
            end
            else if (byte_idx >= 4'd8 && byte_idx <= 4'd11)
            begin
                sender_next = {sender_reg[23:0], byte_val};
            end
            if (at_last)
            begin
                pos_next = '0;
                bad_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
                bad_next = bad_reg || !hex_ok;
            end
        end
    end

    // Sender is complete four characters before frame end; compare every cycle
    assign n_eff = (sensor_count > MAX_CNT) ? MAX_CNT : sensor_count;

    always_comb
    begin
        match_next = 1'b0;
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            if ((3'(i) < n_eff) && (sensor_ids[i] == sender_reg))
            begin
                match_next = 1'b1;
            end
        end
    end

    // Classification from the stored type and data bytes
    always_comb
    begin
        cls    = CLS_4BS;
        cls_ok = 1'b0;
        b1     = ST_ZERO;
        b2     = ST_ZERO;
        priority if (type_reg == TYPE_ROCKER)
        begin
            cls    = CLS_ROCKER;
            cls_ok = 1'b1;
            unique case (data_reg[31:24])
                RK_B1_DOWN:  begin b1 = ST_DOWN; b2 = ST_ZERO; end
                RK_B1_UP:    begin b1 = ST_UP;   b2 = ST_ZERO; end
                RK_B2_DOWN:  begin b1 = ST_ZERO; b2 = ST_DOWN; end
                RK_B2_UP:    begin b1 = ST_ZERO; b2 = ST_UP;   end
                RK_UP_UP:    begin b1 = ST_UP;   b2 = ST_UP;   end
                RK_DN_DN:    begin b1 = ST_DOWN; b2 = ST_DOWN; end
                RK_DN_UP:    begin b1 = ST_DOWN; b2 = ST_UP;   end
                RK_UP_DN:    begin b1 = ST_UP;   b2 = ST_DOWN; end
                RK_RELEASED: begin b1 = ST_ZERO; b2 = ST_ZERO; end
                default:     cls_ok = 1'b0;
            endcase
        end
        else if (type_reg == TYPE_CONTACT)
        begin
            cls = CLS_CONTACT;
            if (data_reg[7:0] == CONTACT_OPEN)
            begin
                cls_ok = 1'b1;
                b1     = ST_ZERO;
            end
            else if (data_reg[7:0] == CONTACT_SHUT)
            begin
                cls_ok = 1'b1;
                b1     = ST_UP;
            end
        end
        else if (type_reg == TYPE_4BS)
        begin
            cls    = CLS_4BS;
            cls_ok = 1'b1;
        end
    end

    assign push_desc.sender = sender_reg;
    assign push_desc.cls    = cls;
    assign push_desc.data   = data_reg;
    assign push_desc.b1     = b1;
    assign push_desc.b2     = b2;

    assign stat.at_last = at_last;
    assign stat.push    = accept && at_last && !bad_reg && hex_ok && match_reg && cls_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hi_reg     <= '0;
            type_reg   <= '0;
            data_reg   <= '0;
            sender_reg <= '0;
            bad_reg    <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            hi_reg     <= hi_next;
            type_reg   <= type_next;
            data_reg   <= data_next;
            sender_reg <= sender_next;
            bad_reg    <= bad_next;
            match_reg  <= match_next;
        end
    end

endmodule

// File: hdl/rtsd_queue.sv
// Short frame queue between front and back ends.
// Depends on rtsd_pkg.
module rtsd_queue
    import rtsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output desc_t head
);

    desc_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg,  count_next;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/rtsd_back.sv
// Back end: expands a queued frame into notification beats.
// Depends on rtsd_pkg and rtsd_note_if.
module rtsd_back
    import rtsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  desc_t         head,
    output logic          pop,
    rtsd_note_if.source   note_out
);

    logic [1:0]        idx_reg, idx_next;
    logic              ov_reg,  ov_next;
    logic [31:0]       id_reg;
    logic [2:0]        kind_reg;
    logic signed [9:0] rd_reg;
    logic              last_reg;

    logic              load;
    logic [2:0]        kind;
    logic signed [9:0] value;
    logic              is_last;
    logic [15:0]       t_scaled;
    logic [15:0]       t_sum;

    // D1*40 by shift-add, then /255 as (x + x/256 + 1) / 256
    assign t_scaled = {3'd0, head.data[15:8], 5'd0} + {5'd0, head.data[15:8], 3'd0};
    assign t_sum    = t_scaled + {8'd0, t_scaled[15:8]} + 16'd1;

    always_comb
    begin
        kind    = KIND_BTN1;
        value   = '0;
        is_last = 1'b1;
        unique case (head.cls)
            CLS_ROCKER:
            begin
                if (idx_reg == 2'd0)
                begin
                    kind    = KIND_BTN1;
                    value   = {{8{head.b1[1]}}, head.b1};
                    is_last = 1'b0;
                end
                else
                begin
                    kind  = KIND_BTN2;
                    value = {{8{head.b2[1]}}, head.b2};
                end
            end
            CLS_CONTACT:
            begin
                kind  = KIND_BTN1;
                value = {{8{head.b1[1]}}, head.b1};
            end
            CLS_4BS:
            begin
                unique case (idx_reg)
                    2'd0:
                    begin
                        kind    = KIND_TEMP;
                        value   = {2'd0, t_sum[15:8]};
                        is_last = 1'b0;
                    end
                    2'd1:
                    begin
                        kind    = KIND_LIGHT;
                        value   = {1'b0, head.data[23:16], 1'b0};
                        is_last = 1'b0;
                    end
                    default:
                    begin
                        kind  = KIND_VOLT;
                        value = {1'b0, head.data[31:24], 1'b0};
                    end
                endcase
            end
            default:
            begin
                kind    = KIND_BTN1;
                value   = '0;
                is_last = 1'b1;
            end
        endcase
    end

    assign load = q_valid && (!ov_reg || note_out.ready);
    assign pop  = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        ov_next  = ov_reg;
        if (load)
        begin
            ov_next  = 1'b1;
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (note_out.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg   <= head.sender;
            kind_reg <= kind;
            rd_reg   <= value;
            last_reg <= is_last;
        end
    end

    assign note_out.valid      = ov_reg;
    assign note_out.sensor_id  = id_reg;
    assign note_out.field_kind = kind_reg;
    assign note_out.reading    = rd_reg;
    assign note_out.last       = last_reg;

endmodule

// File: hdl/radio_telegram_sensor_decoder.sv
// Top level of the radio telegram sensor decoder.
// Depends on rtsd_pkg, rtsd_char_if, rtsd_note_if, rtsd_regs, rtsd_front,
// rtsd_queue and rtsd_back.

// The decoder takes one ASCII hex character per beat on char_in, 28 to a
// telegram, and packs character pairs into bytes. At the final character of
// a telegram whose sender ID matches one of the first sensor_count entries of
// the ID table (and which held no non-hex character), it gives one to three
// notification beats on note_out: two button states for a rocker telegram
// (type 05h), one contact state (type 06h), or temperature, light and supply
// voltage for a 4BS telegram (type 07h); last marks the final beat of each
// telegram. Unknown types or patterns give nothing. Throughput: one
// character per clock while char_in is not stalled; a telegram's
// notifications leave one per clock from the back end while note_out is
// ready, passing through the frame queue and then the output register.
// The two-entry frame queue between front and back only stalls char_in
// at a telegram's last character, and then only while two telegrams are
// still queued behind a stalled note_out. Registers: 0h sensor_count,
// 4h..18h sensor IDs 0..5, written by the user only while the block is
// idle, which the block does not enforce. No clearing pass after reset.
module radio_telegram_sensor_decoder
    import rtsd_pkg::*;
#(
    parameter int unsigned MAX_SENSORS = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    rtsd_char_if.sink           char_in,
    rtsd_note_if.source         note_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [2:0]                   sensor_count;
    logic [MAX_SENSORS-1:0][31:0] sensor_ids;

    desc_t       push_desc;
    desc_t       head;
    front_stat_t front_stat;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    rtsd_regs #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sensor_count (sensor_count),
        .sensor_ids   (sensor_ids)
    );

    // Front: character assembly, ID filter, telegram classification
    rtsd_front #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .sensor_count (sensor_count),
        .sensor_ids   (sensor_ids),
        .q_full       (q_full),
        .push_desc    (push_desc),
        .stat         (front_stat)
    );

    // Decouples the front from a stalled notification sink
    rtsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_stat.push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head)
    );

    // Back: scaling and one notification beat per cycle while note_out is ready
    rtsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (q_pop),
        .note_out (note_out)
    );

    // A telegram is never pushed into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.push |-> !q_full)
        else $error("frame pushed into full queue");

    // Character input only stalls at a telegram's last character
    a_stall_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !char_in.ready |-> front_stat.at_last)
        else $error("character stall away from telegram end");

    // Temperature and light beats are never the last of a telegram
    a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        note_out.valid && (note_out.field_kind == KIND_TEMP ||
                           note_out.field_kind == KIND_LIGHT) |-> !note_out.last)
        else $error("last flag on a mid-telegram beat");

    // Voltage and second button close a telegram
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        note_out.valid && (note_out.field_kind == KIND_VOLT ||
                           note_out.field_kind == KIND_BTN2) |-> note_out.last)
        else $error("closing beat without last flag");

endmodule

// File: tb/tb_radio_telegram_sensor_decoder.sv
// Testbench for the radio telegram sensor decoder: directed and random telegrams,
// checked against an in-bench predictor of the notification stream.
// Depends on rtsd_pkg, rtsd_char_if, rtsd_note_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_radio_telegram_sensor_decoder
    import rtsd_pkg::*;
();

    localparam int MAX_SENSORS  = 6;
    localparam int CYCLE_LIMIT  = 200_000;
    // Extra settle margin once the expected notes have drained.
    localparam int IDLE_SETTLE  = 8;

    // Register indexes
    localparam int REG_SENSOR_ID0 = 1;
    localparam int REG_PAST_END   = 7;

    // Telegram types
    localparam logic [7:0] TYPE_ROCKER  = 8'h05;
    localparam logic [7:0] TYPE_CONTACT = 8'h06;
    localparam logic [7:0] TYPE_4BS     = 8'h07;

    // Rocker D3 patterns
    localparam logic [7:0] RCK_B1_DOWN   = 8'h10;
    localparam logic [7:0] RCK_B1_UP     = 8'h30;
    localparam logic [7:0] RCK_B2_DOWN   = 8'h50;
    localparam logic [7:0] RCK_B2_UP     = 8'h70;
    localparam logic [7:0] RCK_BOTH_UP   = 8'h37;
    localparam logic [7:0] RCK_BOTH_DOWN = 8'h15;
    localparam logic [7:0] RCK_B1D_B2U   = 8'h17;
    localparam logic [7:0] RCK_B1U_B2D   = 8'h35;
    localparam logic [7:0] RCK_RELEASED  = 8'h00;

    // Contact D0 codes
    localparam logic [7:0] CONTACT_OPEN   = 8'h08;
    localparam logic [7:0] CONTACT_CLOSED = 8'h09;

    // Button / contact states
    localparam logic signed [9:0] ST_DOWN = -10'sd1;
    localparam logic signed [9:0] ST_REL  = 10'sd0;
    localparam logic signed [9:0] ST_UP   = 10'sd1;

    // Telegram framing bytes
    localparam logic [7:0] SYNC_HI  = 8'hA5;
    localparam logic [7:0] SYNC_LO  = 8'h5A;
    localparam logic [7:0] LEN_BYTE = 8'h0B;

    // ASCII bases
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [31:0]       sensor_id;
        logic [2:0]        field_kind;
        logic signed [9:0] reading;
        logic              last;
    } note_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    rtsd_char_if char_if ();
    rtsd_note_if note_if ();

    radio_telegram_sensor_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_if),
        .note_out (note_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the register file and of the telegram
    // assembler, advanced once per accepted character beat.
    // ------------------------------------------------------------------
    logic [2:0]  cfg_sensor_count;
    logic [31:0] cfg_sensor_ids [MAX_SENSORS];

    logic [4:0]  tlg_pos;
    logic [3:0]  tlg_hi_nib;
    logic [7:0]  tlg_type;
    logic [31:0] tlg_data;
    logic [31:0] tlg_sender;
    logic        tlg_bad;

    note_t expected_notes [$];

    int mismatch_count = 0;
    int chars_sent     = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int rx_hold_cycles = 0;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Nibble value of an ASCII hex digit, -1 for anything else
    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
            return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
            return int'(c - CH_UPPER_A) + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
            return int'(c - CH_LOWER_A) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n - 4'd10);
    endfunction

    function automatic int active_sensors();
        return (int'(cfg_sensor_count) > MAX_SENSORS) ? MAX_SENSORS : int'(cfg_sensor_count);
    endfunction

    function automatic bit sender_known(input logic [31:0] id);
        int i;
        for (i = 0; i < active_sensors(); i++)
            if (cfg_sensor_ids[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic push_note(input logic [2:0] kind, input logic signed [9:0] value,
                             input logic last);
        note_t n;
        n.sensor_id  = tlg_sender;
        n.field_kind = kind;
        n.reading    = value;
        n.last       = last;
        expected_notes.push_back(n);
    endtask

    // Notifications for a completed, accepted telegram
    task automatic predict_notes();
        logic signed [9:0] b1;
        logic signed [9:0] b2;
        bit                known;
        int                d3;
        int                d2;
        int                d1;
        d3 = int'(tlg_data[31:24]);
        d2 = int'(tlg_data[23:16]);
        d1 = int'(tlg_data[15:8]);
        known = 1'b1;
        b1 = ST_REL;
        b2 = ST_REL;
        case (tlg_type)
            TYPE_ROCKER:
            begin
                case (tlg_data[31:24])
                    RCK_B1_DOWN:   begin b1 = ST_DOWN; b2 = ST_REL;  end
                    RCK_B1_UP:     begin b1 = ST_UP;   b2 = ST_REL;  end
                    RCK_B2_DOWN:   begin b1 = ST_REL;  b2 = ST_DOWN; end
                    RCK_B2_UP:     begin b1 = ST_REL;  b2 = ST_UP;   end
                    RCK_BOTH_UP:   begin b1 = ST_UP;   b2 = ST_UP;   end
                    RCK_BOTH_DOWN: begin b1 = ST_DOWN; b2 = ST_DOWN; end
                    RCK_B1D_B2U:   begin b1 = ST_DOWN; b2 = ST_UP;   end
                    RCK_B1U_B2D:   begin b1 = ST_UP;   b2 = ST_DOWN; end
                    RCK_RELEASED:  begin b1 = ST_REL;  b2 = ST_REL;  end
                    default:       known = 1'b0;
                endcase
                if (known)
                begin
                    push_note(KIND_BTN1, b1, 1'b0);
                    push_note(KIND_BTN2, b2, 1'b1);
                end
            end
            TYPE_CONTACT:
            begin
                if (tlg_data[7:0] == CONTACT_OPEN)
                    push_note(KIND_BTN1, ST_REL, 1'b1);
                else if (tlg_data[7:0] == CONTACT_CLOSED)
                    push_note(KIND_BTN1, ST_UP, 1'b1);
            end
            TYPE_4BS:
            begin
                push_note(KIND_TEMP,  10'((d1 * 40) / 255), 1'b0);
                push_note(KIND_LIGHT, 10'(d2 * 2), 1'b0);
                push_note(KIND_VOLT,  10'(d3 * 2), 1'b1);
            end
            default: ;
        endcase
    endtask

    // One accepted character: pack nibbles, capture fields, close the telegram
    task automatic predict_char(input logic [7:0] c);
        int         nv;
        int         idx;
        logic [3:0] nib;
        logic [7:0] byte_val;
        nv = hex_value(c);
        if (nv < 0)
        begin
            tlg_bad = 1'b1;
            nib = 4'd0;
        end
        else
            nib = 4'(nv);

        if (!tlg_pos[0])
            tlg_hi_nib = nib;
        else
        begin
            byte_val = {tlg_hi_nib, nib};
            idx = int'(tlg_pos >> 1);
            if (idx == 3)
                tlg_type = byte_val;
            else if (idx >= 4 && idx <= 7)
                tlg_data = {tlg_data[23:0], byte_val};
            else if (idx >= 8 && idx <= 11)
                tlg_sender = {tlg_sender[23:0], byte_val};
        end

        if (int'(tlg_pos) == FRAME_CHARS - 1)
        begin
            if (!tlg_bad && sender_known(tlg_sender))
                predict_notes();
            tlg_pos = 5'd0;
            tlg_bad = 1'b0;
        end
        else
            tlg_pos = tlg_pos + 5'd1;
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // idling before return keeps the next setup out of this time step
        @(posedge clk);
    endtask

    task automatic cfg_write(input int index, input logic [31:0] value);
        apb_write(PADDR_W'(index * 4), value);
        if (index == int'(REG_SENSOR_COUNT))
            cfg_sensor_count = value[2:0];
        else if (index >= REG_SENSOR_ID0 && index < REG_SENSOR_ID0 + MAX_SENSORS)
            cfg_sensor_ids[index - REG_SENSOR_ID0] = value;
        // anything past the ID table is ignored by the block
    endtask

    // ------------------------------------------------------------------
    // Character sender. valid stays high across back-to-back beats; a gap
    // drops it first, so no signal sees two NBAs in one step.
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            char_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        char_if.valid    <= 1'b1;
        char_if.hex_char <= c;
        do
            @(posedge clk);
        while (!char_if.ready);
        predict_char(c);
        chars_sent++;
    endtask

    // Full 28-character telegram; bad_at >= 0 swaps that character for bad_ch
    task automatic send_frame(input logic [7:0] ftype, input logic [31:0] data,
                              input logic [31:0] sender, input int bad_at,
                              input logic [7:0] bad_ch);
        logic [7:0] bytes_v [14];
        logic [3:0] nib;
        int         i;
        bytes_v[0]  = SYNC_HI;
        bytes_v[1]  = SYNC_LO;
        bytes_v[2]  = LEN_BYTE;
        bytes_v[3]  = ftype;
        bytes_v[4]  = data[31:24];
        bytes_v[5]  = data[23:16];
        bytes_v[6]  = data[15:8];
        bytes_v[7]  = data[7:0];
        bytes_v[8]  = sender[31:24];
        bytes_v[9]  = sender[23:16];
        bytes_v[10] = sender[15:8];
        bytes_v[11] = sender[7:0];
        bytes_v[12] = 8'($urandom_range(255));   // status
        bytes_v[13] = 8'($urandom_range(255));   // checksum, never checked
        for (i = 0; i < FRAME_CHARS; i++)
        begin
            nib = i[0] ? bytes_v[i / 2][3:0] : bytes_v[i / 2][7:4];
            send_char((i == bad_at) ? bad_ch : hex_digit(nib, 1'($urandom_range(1))));
        end
    endtask

    task automatic send_good(input logic [7:0] ftype, input logic [31:0] data,
                             input logic [31:0] sender);
        send_frame(ftype, data, sender, -1, 8'h00);
    endtask

    // Drop valid, let every expected note drain, then idle for the IDLE_SETTLE margin
    task automatic wait_idle();
        char_if.valid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rocker_code(input int i);
        case (i)
            0:       return RCK_B1_DOWN;
            1:       return RCK_B1_UP;
            2:       return RCK_B2_DOWN;
            3:       return RCK_B2_UP;
            4:       return RCK_BOTH_UP;
            5:       return RCK_BOTH_DOWN;
            6:       return RCK_B1D_B2U;
            7:       return RCK_B1U_B2D;
            default: return RCK_RELEASED;
        endcase
    endfunction

    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (hex_value(c) >= 0);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Notification receiver and checker: samples at the edge, then picks
    // ready for the next cycle (long hold-off first, random stall else).
    // ------------------------------------------------------------------
    task automatic check_note();
        note_t exp_n;
        if (expected_notes.size() == 0)
        begin
            report_error($sformatf("unexpected note id=%h kind=%0d reading=%0d last=%b",
                note_if.sensor_id, note_if.field_kind, note_if.reading, note_if.last));
            return;
        end
        exp_n = expected_notes.pop_front();
        if (note_if.sensor_id !== exp_n.sensor_id)
            report_error($sformatf("sensor_id got %h exp %h",
                note_if.sensor_id, exp_n.sensor_id));
        if (note_if.field_kind !== exp_n.field_kind)
            report_error($sformatf("field_kind got %0d exp %0d",
                note_if.field_kind, exp_n.field_kind));
        if (note_if.reading !== exp_n.reading)
            report_error($sformatf("reading got %0d exp %0d",
                note_if.reading, exp_n.reading));
        if (note_if.last !== exp_n.last)
            report_error($sformatf("last got %b exp %b", note_if.last, exp_n.last));
    endtask

    initial
    begin
        note_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && note_if.valid && note_if.ready)
                check_note();
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                note_if.ready <= 1'b0;
            end
            else
                note_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: count is zero, so even sender 0 must not match
    task automatic test_zero_sensor_count();
        send_good(TYPE_4BS, 32'h1234_5678, 32'h0000_0000);
        send_good(TYPE_ROCKER, {RCK_B1_UP, 24'h0}, 32'h0000_0000);
    endtask

    // ID filtering: count above six, masked count, writes past the table,
    // no match, and a match on the final table entry
    task automatic test_sensor_filter();
        wait_idle();
        cfg_write(REG_SENSOR_ID0 + 0, 32'h0000_0000);
        cfg_write(REG_SENSOR_ID0 + 1, 32'hFFFF_FFFF);
        cfg_write(REG_SENSOR_ID0 + 2, 32'h1234_5678);
        cfg_write(REG_SENSOR_ID0 + 3, 32'hA5A5_5A5A);
        cfg_write(REG_SENSOR_ID0 + 4, 32'h0F1E_2D3C);
        cfg_write(REG_SENSOR_ID0 + 5, 32'h89AB_CDEF);
        cfg_write(int'(REG_SENSOR_COUNT), 32'd7);      // clamps to six
        send_good(TYPE_4BS, 32'hC0FF_EE11, cfg_sensor_ids[5]);
        send_good(TYPE_4BS, 32'hC0FF_EE11, 32'h1111_1111);
        wait_idle();
        cfg_write(int'(REG_SENSOR_COUNT), 32'hFFFF_FFF9); // only low bits count: one
        send_good(TYPE_ROCKER, {RCK_BOTH_UP, 24'hABCDEF}, cfg_sensor_ids[0]);
        send_good(TYPE_ROCKER, {RCK_BOTH_UP, 24'hABCDEF}, cfg_sensor_ids[1]);
        wait_idle();
        cfg_write(REG_PAST_END, 32'h1111_1111);        // must not alias into the table
        send_good(TYPE_4BS, 32'h0102_0304, 32'h1111_1111);
        wait_idle();
        cfg_write(int'(REG_SENSOR_COUNT), 32'(MAX_SENSORS));
    endtask

    task automatic test_rocker_patterns();
        int i;
        for (i = 0; i < 9; i++)
            send_good(TYPE_ROCKER, {rocker_code(i), 24'($urandom)},
                      cfg_sensor_ids[i % MAX_SENSORS]);
        send_good(TYPE_ROCKER, 32'h1100_0000, cfg_sensor_ids[2]);   // unknown pattern
        send_good(TYPE_ROCKER, 32'hFF00_0000, cfg_sensor_ids[3]);
    endtask

    task automatic test_contact();
        send_good(TYPE_CONTACT, {24'($urandom), CONTACT_OPEN}, cfg_sensor_ids[1]);
        send_good(TYPE_CONTACT, {24'($urandom), CONTACT_CLOSED}, cfg_sensor_ids[4]);
        send_good(TYPE_CONTACT, 32'h0000_000A, cfg_sensor_ids[0]);   // unknown code
    endtask

    // Scaling at the data extremes and a few mixed values
    task automatic test_4bs_scaling();
        send_good(TYPE_4BS, 32'h0000_0000, cfg_sensor_ids[2]);
        send_good(TYPE_4BS, 32'hFFFF_FFFF, cfg_sensor_ids[5]);
        send_good(TYPE_4BS, 32'h80FE_0701, cfg_sensor_ids[3]);
        send_good(TYPE_4BS, 32'h0101_FE80, cfg_sensor_ids[1]);
    endtask

    task automatic test_unknown_type();
        send_good(8'h00, 32'h1000_0009, cfg_sensor_ids[0]);
        send_good(8'h04, 32'h1000_0009, cfg_sensor_ids[1]);
        send_good(8'h08, 32'h1000_0009, cfg_sensor_ids[2]);
        send_good(8'hFF, 32'h1000_0009, cfg_sensor_ids[3]);
    endtask

    // Non-hex characters at the ends and at the digit/letter borders;
    // the telegram afterwards must be clean again
    task automatic test_bad_char();
        send_frame(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2], 0, 8'h00);
        send_frame(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2], 27, 8'hFF);
        send_frame(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2], 13, 8'h67);
        send_frame(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2], 7, 8'h2F);
        send_frame(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2], 16, 8'h3A);
        send_frame(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2], 6, 8'h40);
        send_frame(TYPE_ROCKER, {RCK_B1_UP, 24'h0}, cfg_sensor_ids[2], 20, 8'h47);
        send_frame(TYPE_ROCKER, {RCK_B1_UP, 24'h0}, cfg_sensor_ids[2], 22, 8'h60);
        send_good(TYPE_4BS, 32'h5555_AAAA, cfg_sensor_ids[2]);
    endtask

    // Receiver holds off long enough for the frame queue to fill and
    // char_in to stall; afterwards the sender waits for a full drain
    task automatic test_backpressure();
        int i;
        wait_idle();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 600;
        for (i = 0; i < 6; i++)
            send_good(TYPE_4BS, $urandom, cfg_sensor_ids[i % MAX_SENSORS]);
        wait_idle();
        send_good(TYPE_ROCKER, {RCK_B1D_B2U, 24'h0}, cfg_sensor_ids[1]);
        send_good(TYPE_4BS, $urandom, cfg_sensor_ids[4]);
    endtask

    task automatic randomize_sensors();
        int i;
        logic [31:0] id;
        if ($urandom_range(9) == 0)
            cfg_write(int'(REG_SENSOR_COUNT), $urandom_range(1) ? 32'd0 : 32'd7);
        else
            cfg_write(int'(REG_SENSOR_COUNT), 32'($urandom_range(MAX_SENSORS, 1)));
        for (i = 0; i < MAX_SENSORS; i++)
        begin
            if ($urandom_range(7) == 0)
                id = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            else
                id = $urandom;
            cfg_write(REG_SENSOR_ID0 + i, id);
        end
    endtask

    // Mostly recognisable telegrams from configured sensors, with random data
    task automatic send_random_frame(input bit broken);
        logic [7:0]  ftype;
        logic [31:0] data;
        logic [31:0] sender;
        int          r;
        r = $urandom_range(9);
        data = $urandom;
        if (r <= 2)
        begin
            ftype = TYPE_ROCKER;
            if ($urandom_range(9) != 0)
                data[31:24] = rocker_code($urandom_range(8));
        end
        else if (r <= 4)
        begin
            ftype = TYPE_CONTACT;
            if ($urandom_range(9) != 0)
                data[7:0] = $urandom_range(1) ? CONTACT_CLOSED : CONTACT_OPEN;
        end
        else if (r <= 8)
            ftype = TYPE_4BS;
        else
            ftype = 8'($urandom_range(255));
        if (active_sensors() > 0 && $urandom_range(4) != 0)
            sender = cfg_sensor_ids[$urandom_range(active_sensors() - 1)];
        else
            sender = $urandom;
        if (broken)
            send_frame(ftype, data, sender, $urandom_range(FRAME_CHARS - 1),
                       random_bad_char());
        else
            send_good(ftype, data, sender);
    endtask

    // Burst of arbitrary bytes, then hex padding back to a telegram boundary
    task automatic send_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_char(8'($urandom_range(255)));
        while (tlg_pos != 5'd0)
            send_char(hex_digit(4'($urandom_range(15)), 1'($urandom_range(1))));
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_chars);
        int start;
        int r;
        wait_idle();
        randomize_sensors();
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        start = chars_sent;
        while (chars_sent - start < n_chars)
        begin
            r = $urandom_range(99);
            if (r < 75)
                send_random_frame(1'b0);
            else if (r < 88)
                send_random_frame(1'b1);
            else
                send_noise($urandom_range(40, 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Everything known from time zero, with reset asserted
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        char_if.valid    = 1'b0;
        char_if.hex_char = 8'h00;

        cfg_sensor_count = 3'd0;
        foreach (cfg_sensor_ids[i])
            cfg_sensor_ids[i] = 32'h0;
        tlg_pos    = 5'd0;
        tlg_hi_nib = 4'd0;
        tlg_type   = 8'h00;
        tlg_data   = 32'h0;
        tlg_sender = 32'h0;
        tlg_bad    = 1'b0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side
        test_zero_sensor_count();
        test_sensor_filter();
        test_rocker_patterns();
        test_contact();
        test_4bs_scaling();
        test_unknown_type();
        test_bad_char();

        test_backpressure();

        // Random part across the idling phases
        test_random_traffic(0, 0, 130);
        test_random_traffic(77, 0, 130);
        test_random_traffic(0, 77, 130);
        test_random_traffic(23, 23, 130);

        // Drain and let any stray beat show up
        rx_stall_pct = 0;
        wait_idle();
        repeat (4 * IDLE_SETTLE)
            @(posedge clk);
        if (expected_notes.size() != 0)
            report_error($sformatf("%0d notes never arrived", expected_notes.size()));

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
